@@ sv/goi_pkg.sv @@
// ----------------------------------------------------------------------------
// goi_pkg
// Shared types and constants for the obstacle inflation grid.
// ----------------------------------------------------------------------------
`default_nettype none

package goi_pkg;

   localparam int GRID_SIDE  = 128;
   localparam int COORD_W    = $clog2(GRID_SIDE);
   localparam int DIM_W      = COORD_W + 1;
   localparam int ADDR_W     = 2 * COORD_W;
   localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE;
   localparam int CMP_W      = (DIM_W > 11) ? DIM_W : 11;

   localparam int COST_W = 17;
   localparam int WORD_W = COST_W + 1;
   localparam int LOSS_W = 18;

   localparam logic [COST_W-1:0] FULL_VALUE    = 17'd100000;
   localparam logic [LOSS_W-1:0] STRAIGHT_COST = 18'd1000;
   localparam logic [LOSS_W-1:0] DIAGONAL_COST = 18'd1414;

   // value / 1000 as (value * RECIP) >> RECIP_SHIFT, exact for 17-bit values
   localparam int RECIP_W     = 18;
   localparam int RECIP_SHIFT = 27;
   localparam int PROD_W      = COST_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = 18'd134218;

   localparam int VALUE_W = 7;

   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] STEP_SELF_ISSUE = 3'd0;
   localparam logic [STEP_W-1:0] STEP_SELF_TAKE  = 3'd1;
   localparam logic [STEP_W-1:0] STEP_LAST       = 3'd5;

   localparam logic [1:0] CMD_SEED  = 2'd0;
   localparam logic [1:0] CMD_RUN   = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;
   localparam logic [1:0] CMD_CLEAR = 2'd3;

   localparam logic [1:0] KIND_DONE = 2'd0;
   localparam logic [1:0] KIND_READ = 2'd1;
   localparam logic [1:0] KIND_OUT  = 2'd2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DECAY_STEP  = 2'd2;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [11:0] cell_x;
      logic signed [11:0] cell_y;
      logic               is_noise;
   } req_type;

   typedef struct packed {
      logic [1:0]         result_kind;
      logic [VALUE_W-1:0] cell_value;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CLEAR = 5'b00010,
      ST_FWD   = 5'b00100,
      ST_BWD   = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

endpackage

`default_nettype wire

@@ sv/grid_obstacle_inflation.sv @@
// ----------------------------------------------------------------------------
// grid_obstacle_inflation
// Octile chamfer inflation of obstacle seeds over a cost grid held in RAM.
// ----------------------------------------------------------------------------
// Seed commands are written straight into the RAM; a read transaction is
// accepted every cycle while idle and its result passes through the p1, p2
// and rsp registers. A run walks the in-use area twice through the single RAM.
// Reset and clear sweep the RAM one cell per cycle with busy high. Results
// cannot be stalled by the receiver.
`default_nettype none

module grid_obstacle_inflation (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire goi_pkg::req_type                  req_data,
   output logic                                   rsp_valid,
   output goi_pkg::rsp_type                       rsp_data,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [goi_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [goi_pkg::CSR_DATA_W-1:0]    csr_data
);

   goi_pkg::state_type state_ff, state_in;

   logic [7:0] grid_width_ff, grid_width_in;
   logic [7:0] grid_height_ff, grid_height_in;
   logic [6:0] decay_ff, decay_in;

   logic [goi_pkg::LOSS_W-1:0] loss_s_ff, loss_d_ff;

   logic [goi_pkg::ADDR_W-1:0]  clr_ff, clr_in;
   logic [goi_pkg::COORD_W-1:0] x_ff, x_in, y_ff, y_in;
   logic [goi_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [goi_pkg::COST_W-1:0]  acc_ff, acc_in;
   logic                        seed_ff, seed_in;
   logic                        nb_ok_ff, nb_ok_in;
   logic                        nb_diag_ff, nb_diag_in;

   logic                       p1_valid_ff, p1_valid_in;
   logic [1:0]                 p1_kind_ff, p1_kind_in;
   logic                       p2_valid_ff;
   logic [1:0]                 p2_kind_ff;
   logic [goi_pkg::PROD_W-1:0] p2_prod_ff, p2_prod_in;
   logic                       rsp_valid_ff;
   goi_pkg::rsp_type           rsp_data_ff;

   logic                        ram_we;
   logic [goi_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
   logic [goi_pkg::WORD_W-1:0]  ram_wdata, ram_rdata;

   logic [goi_pkg::CMP_W-1:0]  w_cmp, h_cmp, side_cmp, req_x_cmp, req_y_cmp;
   logic [goi_pkg::DIM_W-1:0]  w_eff, h_eff, w_last, h_last;
   logic                       accept, in_grid;
   logic [goi_pkg::ADDR_W-1:0] req_addr;

   logic                       fwd;
   logic [1:0]                 nb_idx;
   logic                       nb_hor, nb_ver, nb_back;
   logic                       x_dec, x_inc, y_dec, y_inc;
   logic [goi_pkg::DIM_W-1:0]  nx, ny;
   logic                       nb_ok;
   logic                       issue_nb;

   logic [goi_pkg::COST_W-1:0] rd_cost;
   logic                       rd_seed;
   logic [goi_pkg::LOSS_W-1:0] loss, rd_ext, cand_ext;
   logic [goi_pkg::COST_W-1:0] cand, relaxed;
   logic                       x_end_fwd, y_end_fwd;

   // --- dimensions and command decode --------------------------------------
   always_comb begin
      side_cmp = goi_pkg::CMP_W'(goi_pkg::GRID_SIDE);
      w_cmp    = goi_pkg::CMP_W'(grid_width_ff);
      h_cmp    = goi_pkg::CMP_W'(grid_height_ff);
      w_eff    = (w_cmp > side_cmp) ? goi_pkg::DIM_W'(goi_pkg::GRID_SIDE)
                                    : goi_pkg::DIM_W'(grid_width_ff);
      h_eff    = (h_cmp > side_cmp) ? goi_pkg::DIM_W'(goi_pkg::GRID_SIDE)
                                    : goi_pkg::DIM_W'(grid_height_ff);
      w_last   = w_eff - goi_pkg::DIM_W'(1);
      h_last   = h_eff - goi_pkg::DIM_W'(1);
      req_x_cmp = goi_pkg::CMP_W'(req_data.cell_x[10:0]);
      req_y_cmp = goi_pkg::CMP_W'(req_data.cell_y[10:0]);
      in_grid = !req_data.cell_x[11] && !req_data.cell_y[11]
                && (req_x_cmp < goi_pkg::CMP_W'(w_eff))
                && (req_y_cmp < goi_pkg::CMP_W'(h_eff));
      req_addr = {req_data.cell_y[goi_pkg::COORD_W-1:0],
                  req_data.cell_x[goi_pkg::COORD_W-1:0]};
      accept = start && (state_ff == goi_pkg::ST_IDLE);
   end

   assign busy      = (state_ff != goi_pkg::ST_IDLE);
   assign csr_ready = 1'b1;

   // --- neighbor selection --------------------------------------------------
   always_comb begin
      fwd    = (state_ff == goi_pkg::ST_FWD);
      nb_idx = 2'(step_ff - goi_pkg::STEP_W'(1));
      nb_hor  = 1'b0;
      nb_ver  = 1'b0;
      nb_back = 1'b0;
      case (nb_idx)
         2'd0: begin
            nb_hor  = 1'b1;
            nb_back = 1'b1;
         end
         2'd1: begin
            nb_hor  = 1'b1;
            nb_ver  = 1'b1;
            nb_back = 1'b1;
         end
         2'd2: begin
            nb_ver = 1'b1;
         end
         default: begin
            nb_hor = 1'b1;
            nb_ver = 1'b1;
         end
      endcase
      x_dec = nb_hor && (fwd ? nb_back : !nb_back);
      x_inc = nb_hor && !x_dec;
      y_dec = nb_ver && fwd;
      y_inc = nb_ver && !fwd;
      nx = x_dec ? ({1'b0, x_ff} - goi_pkg::DIM_W'(1))
         : x_inc ? ({1'b0, x_ff} + goi_pkg::DIM_W'(1)) : {1'b0, x_ff};
      ny = y_dec ? ({1'b0, y_ff} - goi_pkg::DIM_W'(1))
         : y_inc ? ({1'b0, y_ff} + goi_pkg::DIM_W'(1)) : {1'b0, y_ff};
      nb_ok = !(x_dec && x_ff == '0) && !(x_inc && nx >= w_eff)
              && !(y_dec && y_ff == '0) && !(y_inc && ny >= h_eff);
      issue_nb = (step_ff >= goi_pkg::STEP_SELF_TAKE) && (step_ff < goi_pkg::STEP_LAST);
   end

   // --- relaxation ----------------------------------------------------------
   always_comb begin
      rd_cost  = ram_rdata[goi_pkg::COST_W-1:0];
      rd_seed  = ram_rdata[goi_pkg::COST_W];
      loss     = nb_diag_ff ? loss_d_ff : loss_s_ff;
      rd_ext   = goi_pkg::LOSS_W'(rd_cost);
      cand_ext = (rd_ext > loss) ? (rd_ext - loss) : '0;
      cand     = cand_ext[goi_pkg::COST_W-1:0];
      relaxed  = (nb_ok_ff && cand > acc_ff) ? cand : acc_ff;
      x_end_fwd = ({1'b0, x_ff} == w_last);
      y_end_fwd = ({1'b0, y_ff} == h_last);
   end

   // --- RAM ports ------------------------------------------------------------
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = {y_ff, x_ff};
      ram_wdata = {seed_ff, relaxed};
      ram_raddr = req_addr;
      unique case (state_ff)
         goi_pkg::ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
         end
         goi_pkg::ST_FWD, goi_pkg::ST_BWD: begin
            ram_we    = (step_ff == goi_pkg::STEP_LAST);
            ram_raddr = (step_ff == goi_pkg::STEP_SELF_ISSUE)
                        ? {y_ff, x_ff}
                        : {ny[goi_pkg::COORD_W-1:0], nx[goi_pkg::COORD_W-1:0]};
         end
         goi_pkg::ST_DONE: begin
         end
         default: begin
            if (accept && req_data.cmd == goi_pkg::CMD_SEED
                && !req_data.is_noise && in_grid) begin
               ram_we    = 1'b1;
               ram_waddr = req_addr;
               ram_wdata = {1'b1, goi_pkg::FULL_VALUE};
            end
         end
      endcase
   end

   goi_ram #(
      .WIDTH (goi_pkg::WORD_W),
      .DEPTH (goi_pkg::CELL_COUNT)
   ) u_grid_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // --- control -------------------------------------------------------------
   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      step_in    = step_ff;
      acc_in     = relaxed;
      seed_in    = seed_ff;
      nb_ok_in   = issue_nb && nb_ok;
      nb_diag_in = nb_hor && nb_ver;
      p1_valid_in = 1'b0;
      p1_kind_in  = goi_pkg::KIND_DONE;

      unique case (state_ff)
         goi_pkg::ST_CLEAR: begin
            clr_in = clr_ff + goi_pkg::ADDR_W'(1);
            if (clr_ff == goi_pkg::ADDR_W'(goi_pkg::CELL_COUNT - 1)) begin
               state_in = goi_pkg::ST_IDLE;
            end
         end
         goi_pkg::ST_FWD, goi_pkg::ST_BWD: begin
            if (step_ff == goi_pkg::STEP_SELF_TAKE) begin
               acc_in  = fwd ? (rd_seed ? goi_pkg::FULL_VALUE : '0) : rd_cost;
               seed_in = rd_seed;
            end
            if (step_ff == goi_pkg::STEP_LAST) begin
               step_in = goi_pkg::STEP_SELF_ISSUE;
               if (fwd) begin
                  if (x_end_fwd) begin
                     x_in = '0;
                     y_in = y_ff + goi_pkg::COORD_W'(1);
                     if (y_end_fwd) begin
                        state_in = goi_pkg::ST_BWD;
                        x_in     = w_last[goi_pkg::COORD_W-1:0];
                        y_in     = h_last[goi_pkg::COORD_W-1:0];
                     end
                  end else begin
                     x_in = x_ff + goi_pkg::COORD_W'(1);
                  end
               end else begin
                  if (x_ff == '0) begin
                     x_in = w_last[goi_pkg::COORD_W-1:0];
                     y_in = y_ff - goi_pkg::COORD_W'(1);
                     if (y_ff == '0) begin
                        state_in = goi_pkg::ST_DONE;
                     end
                  end else begin
                     x_in = x_ff - goi_pkg::COORD_W'(1);
                  end
               end
            end else begin
               step_in = step_ff + goi_pkg::STEP_W'(1);
            end
         end
         goi_pkg::ST_DONE: begin
            p1_valid_in = 1'b1;
            p1_kind_in  = goi_pkg::KIND_DONE;
            state_in    = goi_pkg::ST_IDLE;
         end
         default: begin
            if (accept) begin
               case (req_data.cmd)
                  goi_pkg::CMD_RUN: begin
                     x_in    = '0;
                     y_in    = '0;
                     step_in = goi_pkg::STEP_SELF_ISSUE;
                     state_in = (w_eff == '0 || h_eff == '0) ? goi_pkg::ST_DONE
                                                             : goi_pkg::ST_FWD;
                  end
                  goi_pkg::CMD_READ: begin
                     p1_valid_in = 1'b1;
                     p1_kind_in  = in_grid ? goi_pkg::KIND_READ : goi_pkg::KIND_OUT;
                  end
                  goi_pkg::CMD_CLEAR: begin
                     clr_in   = '0;
                     state_in = goi_pkg::ST_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end
      endcase
   end

   // --- configuration -------------------------------------------------------
   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      decay_in       = decay_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            goi_pkg::CSR_GRID_WIDTH:  grid_width_in  = csr_data;
            goi_pkg::CSR_GRID_HEIGHT: grid_height_in = csr_data;
            goi_pkg::CSR_DECAY_STEP:  decay_in       = csr_data[6:0];
            default: begin
            end
         endcase
      end
   end

   assign p2_prod_in = (p1_kind_ff == goi_pkg::KIND_READ)
                       ? goi_pkg::PROD_W'(rd_cost) * goi_pkg::PROD_W'(goi_pkg::RECIP)
                       : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= goi_pkg::ST_CLEAR;
         clr_ff         <= '0;
         x_ff           <= '0;
         y_ff           <= '0;
         step_ff        <= goi_pkg::STEP_SELF_ISSUE;
         p1_valid_ff    <= 1'b0;
         p2_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         grid_width_ff  <= 8'd100;
         grid_height_ff <= 8'd100;
         decay_ff       <= 7'd5;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         x_ff           <= x_in;
         y_ff           <= y_in;
         step_ff        <= step_in;
         p1_valid_ff    <= p1_valid_in;
         p2_valid_ff    <= p1_valid_ff;
         rsp_valid_ff   <= p2_valid_ff;
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         decay_ff       <= decay_in;
      end
      acc_ff     <= acc_in;
      seed_ff    <= seed_in;
      nb_ok_ff   <= nb_ok_in;
      nb_diag_ff <= nb_diag_in;
      loss_s_ff  <= goi_pkg::LOSS_W'(decay_ff) * goi_pkg::STRAIGHT_COST;
      loss_d_ff  <= goi_pkg::LOSS_W'(decay_ff) * goi_pkg::DIAGONAL_COST;
      p1_kind_ff <= p1_kind_in;
      p2_kind_ff <= p1_kind_ff;
      p2_prod_ff <= p2_prod_in;
      rsp_data_ff.result_kind <= p2_kind_ff;
      rsp_data_ff.cell_value  <= p2_prod_ff[goi_pkg::RECIP_SHIFT +: goi_pkg::VALUE_W];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // --- assertions ----------------------------------------------------------
   a_run_start: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.cmd == goi_pkg::CMD_RUN
      |=> state_ff == goi_pkg::ST_FWD || state_ff == goi_pkg::ST_DONE)
      else $error("run transaction did not start a pass");

   a_walk_in_area: assert property (@(posedge clock) disable iff (reset)
      state_ff == goi_pkg::ST_FWD || state_ff == goi_pkg::ST_BWD
      |-> {1'b0, x_ff} < w_eff && {1'b0, y_ff} < h_eff)
      else $error("pass left the in-use area");

   a_cost_bound: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ram_wdata[goi_pkg::COST_W-1:0] <= goi_pkg::FULL_VALUE)
      else $error("cell cost above full value");

   a_done_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == goi_pkg::KIND_DONE
      |-> $past(state_ff == goi_pkg::ST_DONE, 3))
      else $error("inflation done without finished passes");

endmodule

`default_nettype wire

@@ sv/goi_ram.sv @@
// ----------------------------------------------------------------------------
// goi_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module goi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
